@@ rtl/can_error_state_tracker_assert.svh @@
// assertion macros for the can error state tracker
`ifndef CAN_ERROR_STATE_TRACKER_ASSERT_SVH
`define CAN_ERROR_STATE_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CEST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CEST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/can_est_pkg.sv @@
// shared types and constants of the can error state tracker
`timescale 1ns / 1ps
`default_nettype none

package can_est_pkg;

  localparam int MAX_DATA_BYTES = 8;

  // request kinds
  localparam logic [1:0] REQ_STATUS  = 2'd0;
  localparam logic [1:0] REQ_FRAME   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // error states
  localparam logic [1:0] ST_ACTIVE  = 2'd0;
  localparam logic [1:0] ST_WARNING = 2'd1;
  localparam logic [1:0] ST_PASSIVE = 2'd2;
  localparam logic [1:0] ST_BUSOFF  = 2'd3;

  // interrupt flag bits
  localparam int IF_TX_DONE = 0;
  localparam int IF_ERROR   = 2;

  // error flag bits
  localparam int EF_RX_OVF     = 0;
  localparam int EF_BUSOFF     = 1;
  localparam int EF_TX_PASSIVE = 2;
  localparam int EF_RX_PASSIVE = 3;
  localparam int EF_TX_WARN    = 4;
  localparam int EF_RX_WARN    = 5;
  localparam int EF_TX_OVF     = 7;

  // error frame class bits
  localparam logic [8:0] CLS_CTRL    = 9'h004;
  localparam logic [8:0] CLS_BUSOFF  = 9'h040;
  localparam logic [8:0] CLS_RESTART = 9'h100;

  // controller detail bits
  localparam logic [7:0] DET_RX_OVF     = 8'h01;
  localparam logic [7:0] DET_TX_OVF     = 8'h02;
  localparam logic [7:0] DET_RX_WARN    = 8'h04;
  localparam logic [7:0] DET_TX_WARN    = 8'h08;
  localparam logic [7:0] DET_RX_PASSIVE = 8'h10;
  localparam logic [7:0] DET_TX_PASSIVE = 8'h20;

  localparam logic [3:0] DLC_MAX = 4'(MAX_DATA_BYTES);

  // decoded item handed from the front to the back
  typedef struct packed {
    logic [1:0] req;
    logic [1:0] level;
    logic [8:0] cls;
    logic [7:0] det;
    logic       rx_ovf;
    logic       tx_ovf;
    logic       tx_done;
    logic [3:0] len1;     // clamped length plus one
  } cmd_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [8:0]  cls;
    logic [7:0]  det;
    logic [1:0]  bus_state;
    logic        halted;
    logic        released;
    logic        dropped;
    logic [31:0] warn_cnt;
    logic [31:0] pass_cnt;
    logic [31:0] busoff_cnt;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/can_error_state_tracker.sv @@
// Tracks a CAN controller's error state from status, frame-sent and restart
// items and reports error frames and a status result for each item. Every
// item yields one to three result items, error frames first and the status
// result last (tlast). The back end drives one result per cycle into the
// output register while the output is not stalled by out_tready: a frame-sent
// item yields one result, a status item with both overflows three, a restart
// two. A two-entry command queue lets new items be taken while results still
// wait at the output. Configuration is always ready.
`timescale 1ns / 1ps
`default_nettype none

module can_error_state_tracker
  import can_est_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic         cfg_data,    // auto_restart_enabled
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [1:0]   in_tuser,    // req_type
  input  wire logic [15:0]  in_tdata,    // int_flags, error_flags, data_length, pad
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic         out_tuser,   // item_kind
  // err_class, err_detail, bus_state, bus_off_entered, tx_released, tx_dropped,
  // warning_count, passive_count, busoff_count, pad
  output      logic [119:0] out_tdata,
  output      logic         out_tlast
);

`include "can_error_state_tracker_assert.svh"

  logic auto_restart_r;
  logic auto_restart_nxt;
  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_head;
  res_t res;

  assign cfg_ready        = 1'b1;
  assign auto_restart_nxt = (cfg_valid && cfg_ready) ? cfg_data : auto_restart_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_restart_r <= 1'b0;
    end else begin
      auto_restart_r <= auto_restart_nxt;
    end
  end

  can_est_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  can_est_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  can_est_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .auto_restart (auto_restart_r),
    .cmd_valid    (q_not_empty),
    .cmd          (q_head),
    .cmd_pop      (q_pop),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res          (res)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.last;
  assign out_tdata = {2'b00, res.busoff_cnt, res.pass_cnt, res.warn_cnt, res.dropped,
                      res.released, res.halted, res.bus_state, res.det, res.cls};

  // error frames are never last, the status result always is
  `CEST_ASSERT_NOW(a_last_is_status, out_tvalid, out_tuser != out_tlast,
                   "result kind and tlast disagree")
  // a bus-off halt leaves the state in bus-off and releases no frame
  `CEST_ASSERT_NOW(a_halt_state, out_tvalid && !out_tuser && out_tdata[19],
                   out_tdata[18:17] == ST_BUSOFF && !out_tdata[20],
                   "bus-off halt with wrong state or release")
  // the command queue is only popped when it holds an item
  `CEST_ASSERT_NOW(a_pop_nonempty, q_pop, q_not_empty, "pop from empty command queue")
  // a pop always puts a result in the output register
  `CEST_ASSERT_NEXT(a_pop_result, q_pop, out_tvalid, "popped item left no result")

endmodule

`default_nettype wire

@@ rtl/can_est_front.sv @@
// input side: accepts items and decodes the flags into a command
`timescale 1ns / 1ps
`default_nettype none

module can_est_front
  import can_est_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [1:0]  in_tuser,   // req_type
  input  wire logic [15:0] in_tdata,   // int_flags, error_flags, data_length, pad
  input  wire logic        q_full,
  output      logic        q_push,
  output      cmd_t        q_cmd
);

  logic [2:0] int_flags;
  logic [7:0] err_flags;
  logic [3:0] dlc;
  logic       seen_r;
  logic       seen_nxt;

  assign int_flags = in_tdata[2:0];
  assign err_flags = in_tdata[10:3];
  assign dlc       = in_tdata[14:11];

  assign in_tready = !q_full && seen_r;
  assign q_push    = in_tvalid && in_tready;

  // hold off the first accept until reset has been seen released
  assign seen_nxt = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  always_comb begin
    q_cmd         = '0;
    q_cmd.req     = in_tuser;
    q_cmd.rx_ovf  = int_flags[IF_ERROR] && err_flags[EF_RX_OVF];
    q_cmd.tx_ovf  = int_flags[IF_ERROR] && err_flags[EF_TX_OVF];
    q_cmd.tx_done = int_flags[IF_TX_DONE];
    q_cmd.len1    = (dlc > DLC_MAX) ? DLC_MAX + 4'd1 : dlc + 4'd1;
    // highest-priority error flag picks the level
    if (err_flags[EF_BUSOFF]) begin
      q_cmd.level = ST_BUSOFF;
      q_cmd.cls   = CLS_BUSOFF;
    end else if (err_flags[EF_TX_PASSIVE]) begin
      q_cmd.level = ST_PASSIVE;
      q_cmd.cls   = CLS_CTRL;
      q_cmd.det   = DET_TX_PASSIVE;
    end else if (err_flags[EF_RX_PASSIVE]) begin
      q_cmd.level = ST_PASSIVE;
      q_cmd.cls   = CLS_CTRL;
      q_cmd.det   = DET_RX_PASSIVE;
    end else if (err_flags[EF_TX_WARN]) begin
      q_cmd.level = ST_WARNING;
      q_cmd.cls   = CLS_CTRL;
      q_cmd.det   = DET_TX_WARN;
    end else if (err_flags[EF_RX_WARN]) begin
      q_cmd.level = ST_WARNING;
      q_cmd.cls   = CLS_CTRL;
      q_cmd.det   = DET_RX_WARN;
    end else begin
      q_cmd.level = ST_ACTIVE;
    end
  end

endmodule

`default_nettype wire

@@ rtl/can_est_fifo.sv @@
// two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module can_est_fifo
  import can_est_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output      logic full,
  input  wire logic pop,
  output      logic not_empty,
  output      cmd_t head
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/can_est_back.sv @@
// back end: error state, counters and result sequencing
`timescale 1ns / 1ps
`default_nettype none

module can_est_back
  import can_est_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic auto_restart,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output      logic cmd_pop,
  output      logic res_valid,
  input  wire logic res_ready,
  output      res_t res
);

  // architectural state
  logic [1:0]  state_r,    state_nxt;
  logic [3:0]  pend_r,     pend_nxt;
  logic [31:0] warn_r,     warn_nxt;
  logic [31:0] pass_r,     pass_nxt;
  logic [31:0] busoff_r,   busoff_nxt;
  logic [31:0] txpkt_r,    txpkt_nxt;
  logic [31:0] txbyte_r,   txbyte_nxt;
  logic [31:0] rxovf_r,    rxovf_nxt;
  logic [31:0] txovf_r,    txovf_nxt;
  logic [31:0] txerr_r,    txerr_nxt;

  // results still owed for the item in flight
  logic        st_pend_r,  st_pend_nxt;
  logic        fr_pend_r,  fr_pend_nxt;
  logic [8:0]  fr_cls_r,   fr_cls_nxt;
  logic [7:0]  fr_det_r,   fr_det_nxt;
  logic        halt_r,     halt_nxt;
  logic        rel_r,      rel_nxt;
  logic        drop_r,     drop_nxt;

  // output register
  logic        out_vld_r,  out_vld_nxt;
  res_t        out_r,      out_nxt;

  logic        ld;
  logic        halted;
  logic        released;
  logic        dropped;
  logic [1:0]  nfr;
  logic [8:0]  fa_cls;
  logic [7:0]  fa_det;
  logic [8:0]  fb_cls;
  logic [7:0]  fb_det;
  logic [8:0]  ovf_cls;
  logic [7:0]  rx_det;
  logic [7:0]  tx_det;
  res_t        status_res;

  assign ld        = !out_vld_r || res_ready;
  assign cmd_pop   = ld && !st_pend_r && cmd_valid;
  assign res_valid = out_vld_r;
  assign res       = out_r;

  // item execution: all state moves on the pop cycle
  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    warn_nxt   = warn_r;
    pass_nxt   = pass_r;
    busoff_nxt = busoff_r;
    txpkt_nxt  = txpkt_r;
    txbyte_nxt = txbyte_r;
    rxovf_nxt  = rxovf_r;
    txovf_nxt  = txovf_r;
    txerr_nxt  = txerr_r;
    halted     = 1'b0;
    released   = 1'b0;
    dropped    = 1'b0;
    nfr        = 2'd0;
    fa_cls     = '0;
    fa_det     = '0;
    fb_cls     = '0;
    fb_det     = '0;
    ovf_cls    = cmd.cls | CLS_CTRL;
    rx_det     = cmd.det | DET_RX_OVF;
    tx_det     = (cmd.rx_ovf ? rx_det : cmd.det) | DET_TX_OVF;
    if (cmd_pop) begin
      case (cmd.req)
        REQ_STATUS: begin
          if (state_r == ST_ACTIVE && cmd.level != ST_ACTIVE) begin
            warn_nxt = warn_r + 32'd1;
          end
          if (state_r <= ST_WARNING && cmd.level >= ST_PASSIVE) begin
            pass_nxt = pass_r + 32'd1;
          end
          state_nxt = cmd.level;
          // overflow frames carry the bits of the ones before them
          if (cmd.rx_ovf) begin
            rxovf_nxt = rxovf_r + 32'd1;
            fa_cls    = ovf_cls;
            fa_det    = rx_det;
            nfr       = 2'd1;
          end
          if (cmd.tx_ovf) begin
            txovf_nxt = txovf_r + 32'd1;
            txerr_nxt = txerr_r + 32'd1;
            if (cmd.rx_ovf) begin
              fb_cls = ovf_cls;
              fb_det = tx_det;
              nfr    = 2'd2;
            end else begin
              fa_cls = ovf_cls;
              fa_det = tx_det;
              nfr    = 2'd1;
            end
          end
          if (cmd.level == ST_BUSOFF && !auto_restart) begin
            busoff_nxt = busoff_r + 32'd1;
            halted     = 1'b1;
          end else if (cmd.tx_done) begin
            txpkt_nxt = txpkt_r + 32'd1;
            if (pend_r != 4'd0) begin
              txbyte_nxt = txbyte_r + {28'd0, pend_r - 4'd1};
              pend_nxt   = 4'd0;
            end
            released = 1'b1;
          end
        end
        REQ_FRAME: begin
          if (state_r == ST_BUSOFF) begin
            txerr_nxt = txerr_r + 32'd1;
            pend_nxt  = 4'd0;
            dropped   = 1'b1;
          end else begin
            pend_nxt = cmd.len1;
          end
        end
        REQ_RESTART: begin
          if (pend_r != 4'd0) begin
            txerr_nxt = txerr_r + 32'd1;
            dropped   = 1'b1;
          end
          pend_nxt  = 4'd0;
          state_nxt = ST_ACTIVE;
          released  = 1'b1;
          fa_cls    = CLS_RESTART;
          nfr       = 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // result sequencing into the output register
  always_comb begin
    st_pend_nxt = st_pend_r;
    fr_pend_nxt = fr_pend_r;
    fr_cls_nxt  = fr_cls_r;
    fr_det_nxt  = fr_det_r;
    halt_nxt    = halt_r;
    rel_nxt     = rel_r;
    drop_nxt    = drop_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;

    status_res            = '0;
    status_res.bus_state  = state_nxt;
    status_res.warn_cnt   = warn_nxt;
    status_res.pass_cnt   = pass_nxt;
    status_res.busoff_cnt = busoff_nxt;
    status_res.last       = 1'b1;

    if (ld) begin
      out_nxt = '0;
      if (st_pend_r) begin
        out_vld_nxt = 1'b1;
        if (fr_pend_r) begin
          out_nxt.kind = 1'b1;
          out_nxt.cls  = fr_cls_r;
          out_nxt.det  = fr_det_r;
          fr_pend_nxt  = 1'b0;
        end else begin
          out_nxt          = status_res;
          out_nxt.halted   = halt_r;
          out_nxt.released = rel_r;
          out_nxt.dropped  = drop_r;
          st_pend_nxt      = 1'b0;
        end
      end else if (cmd_pop) begin
        out_vld_nxt = 1'b1;
        if (nfr == 2'd0) begin
          out_nxt          = status_res;
          out_nxt.halted   = halted;
          out_nxt.released = released;
          out_nxt.dropped  = dropped;
        end else begin
          out_nxt.kind = 1'b1;
          out_nxt.cls  = fa_cls;
          out_nxt.det  = fa_det;
          st_pend_nxt  = 1'b1;
          fr_pend_nxt  = (nfr == 2'd2);
          fr_cls_nxt   = fb_cls;
          fr_det_nxt   = fb_det;
          halt_nxt     = halted;
          rel_nxt      = released;
          drop_nxt     = dropped;
        end
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_ACTIVE;
      pend_r    <= 4'd0;
      warn_r    <= 32'd0;
      pass_r    <= 32'd0;
      busoff_r  <= 32'd0;
      txpkt_r   <= 32'd0;
      txbyte_r  <= 32'd0;
      rxovf_r   <= 32'd0;
      txovf_r   <= 32'd0;
      txerr_r   <= 32'd0;
      st_pend_r <= 1'b0;
      fr_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      warn_r    <= warn_nxt;
      pass_r    <= pass_nxt;
      busoff_r  <= busoff_nxt;
      txpkt_r   <= txpkt_nxt;
      txbyte_r  <= txbyte_nxt;
      rxovf_r   <= rxovf_nxt;
      txovf_r   <= txovf_nxt;
      txerr_r   <= txerr_nxt;
      st_pend_r <= st_pend_nxt;
      fr_pend_r <= fr_pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_cls_r <= fr_cls_nxt;
    fr_det_r <= fr_det_nxt;
    halt_r   <= halt_nxt;
    rel_r    <= rel_nxt;
    drop_r   <= drop_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire
